// ===== sv/lecp_pkg.sv =====
// Shared types, codes and constants for the LED channel effect PWM block.
`timescale 1ns / 1ps

package lecp_pkg;

    // Channel count default and fixed widths
    localparam int CHANNELS_DEF   = 4;
    localparam int CFG_CHANNELS   = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int BLINK_SCALE    = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_INT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF = 3'd4;

    // Configuration reset values
    localparam logic [7:0]            MODES_RST     = 8'h00;
    localparam logic [CFG_DATA_W-1:0] DIM_RST       = 32'h7F7F_7F7F;
    localparam logic [CFG_DATA_W-1:0] FADE_INT_RST  = 32'h0A0A_0A0A;
    localparam logic [CFG_DATA_W-1:0] BLINK_ON_RST  = 32'h1414_1414;
    localparam logic [CFG_DATA_W-1:0] BLINK_OFF_RST = 32'h7F7F_7F7F;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CMD  = 2'd0;
    localparam kind_t KIND_SLOW = 2'd1;
    localparam kind_t KIND_PWM  = 2'd2;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_ONOFF = 2'd0;
    localparam mode_t MODE_FADE  = 2'd1;
    localparam mode_t MODE_BLINK = 2'd2;
    localparam mode_t MODE_NEON  = 2'd3;

    typedef logic [1:0] chan_state_t;
    localparam chan_state_t ST_OFF  = 2'd0;
    localparam chan_state_t ST_ON   = 2'd1;
    localparam chan_state_t ST_UP   = 2'd2;
    localparam chan_state_t ST_DOWN = 2'd3;

    // Per-channel configuration slice
    typedef struct packed {
        mode_t      mode;
        logic [7:0] dim;
        logic [7:0] fade_int;
        logic [7:0] on_time;
        logic [7:0] off_time;
    } lane_cfg_t;

    // Per-channel effect state
    typedef struct packed {
        chan_state_t state;
        logic [7:0]  duty;
        logic [15:0] evt_time;
    } lane_st_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] on_requests;
    } in_item_t;

    typedef struct packed {
        logic [3:0] pin_levels;
        logic [7:0] duty_ch0;
        logic [7:0] duty_ch1;
        logic [7:0] duty_ch2;
        logic [7:0] duty_ch3;
    } out_item_t;

endpackage

// ===== sv/lecp_lane.sv =====
// Next-state logic of one light channel: switching, fade steps and blink toggles.
`timescale 1ns / 1ps

module lecp_lane (
    input  lecp_pkg::kind_t     kind,
    input  logic                want,
    input  logic [15:0]         tick_next,
    input  lecp_pkg::lane_cfg_t cfg,
    input  lecp_pkg::lane_st_t  cur,
    output lecp_pkg::lane_st_t  nxt
);
    import lecp_pkg::*;

    logic        tick_hit;
    logic        going_up;
    logic [7:0]  ramp_duty;
    logic [7:0]  ramp_target;
    logic        lit;
    logic [7:0]  wait_units;
    logic [15:0] blink_wait;

    assign tick_hit    = (tick_next == cur.evt_time);
    assign going_up    = (cur.state == ST_UP);
    assign ramp_duty   = going_up ? cur.duty + 8'd1 : cur.duty - 8'd1;
    assign ramp_target = going_up ? cfg.dim : 8'd0;
    assign lit         = (cur.duty != 8'd0);
    assign wait_units  = lit ? cfg.off_time : cfg.on_time;
    // Scale the wait by ten as shift-and-add
    assign blink_wait  = ({8'd0, wait_units} << 3) + ({8'd0, wait_units} << 1);

    always_comb
    begin
        nxt = cur;
        case (kind)
            KIND_CMD:
            begin
                if (want)
                begin
                    // Switch on from dark or fading down
                    if (cur.state inside {ST_OFF, ST_DOWN})
                    begin
                        case (cfg.mode)
                            MODE_ONOFF:
                            begin
                                nxt.duty  = cfg.dim;
                                nxt.state = ST_ON;
                            end
                            MODE_BLINK: nxt.state = ST_ON;
                            default:    nxt.state = ST_UP;
                        endcase
                    end
                end
                else if (cur.state inside {ST_ON, ST_UP})
                begin
                    // Switch off: fade ramps down, others go dark at once
                    if (cfg.mode == MODE_FADE)
                    begin
                        nxt.state = ST_DOWN;
                    end
                    else
                    begin
                        nxt.duty  = 8'd0;
                        nxt.state = ST_OFF;
                    end
                end
            end
            KIND_SLOW:
            begin
                // Step the fade by one and schedule the next step
                if (cfg.mode == MODE_FADE && (cur.state inside {ST_UP, ST_DOWN}) && tick_hit)
                begin
                    nxt.evt_time = cur.evt_time + {8'd0, cfg.fade_int};
                    nxt.duty     = ramp_duty;
                    if (ramp_duty == ramp_target)
                    begin
                        nxt.state = going_up ? ST_ON : ST_OFF;
                    end
                end
                // Toggle the blink and schedule the next toggle
                else if (cfg.mode == MODE_BLINK && cur.state == ST_ON && tick_hit)
                begin
                    nxt.evt_time = cur.evt_time + blink_wait;
                    nxt.duty     = lit ? 8'd0 : cfg.dim;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/led_channel_effect_pwm.sv =====
// Top level of the LED channel effect PWM block: registers, channel lanes and result stage.
`timescale 1ns / 1ps

// Channel  | Signals                          | Transfer when
// ---------+----------------------------------+--------------------------
// input    | in_valid, in_ready, in_data      | in_valid && in_ready
// output   | out_valid, out_ready, out_data   | out_valid && out_ready
// config   | cfg_we, cfg_index, cfg_data      | cfg_we high at clock edge
//
// For each item, all lanes compute their next state from the held
// state and the incoming item, and the result register loads at the same edge.
// A new item is taken every cycle while the result register is empty or being
// drained; a stall on the output holds in_ready low only while a result waits.
// Reset (rst_n, asynchronous) clears all channel state and loads config defaults.

module led_channel_effect_pwm #(
    parameter int CHANNELS = lecp_pkg::CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lecp_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lecp_pkg::out_item_t                out_data,
    input  logic                               cfg_we,
    input  logic [lecp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lecp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lecp_pkg::*;

    logic [7:0]            modes_reg;
    logic [CFG_DATA_W-1:0] dim_reg;
    logic [CFG_DATA_W-1:0] fade_int_reg;
    logic [CFG_DATA_W-1:0] blink_on_reg;
    logic [CFG_DATA_W-1:0] blink_off_reg;

    logic [15:0] slow_cnt_reg;
    logic [15:0] slow_cnt_next;
    logic [7:0]  pwm_phase_reg;
    logic [3:0]  pin_reg;
    logic [3:0]  pin_next;
    logic [3:0]  pwm_pins;

    lane_st_t  lane_reg  [CHANNELS];
    lane_st_t  lane_next [CHANNELS];
    lane_cfg_t lane_cfg  [CHANNELS];
    logic      lane_want [CHANNELS];

    logic [7:0] duty_cur [CFG_CHANNELS];
    logic [7:0] duty_rep [CFG_CHANNELS];

    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic      in_xfer;

    assign in_ready      = !out_valid_reg || out_ready;
    assign in_xfer       = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
    assign slow_cnt_next = slow_cnt_reg + 16'd1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg     <= MODES_RST;
            dim_reg       <= DIM_RST;
            fade_int_reg  <= FADE_INT_RST;
            blink_on_reg  <= BLINK_ON_RST;
            blink_off_reg <= BLINK_OFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODES:     modes_reg     <= cfg_data[7:0];
                REG_DIM:       dim_reg       <= cfg_data;
                REG_FADE_INT:  fade_int_reg  <= cfg_data;
                REG_BLINK_ON:  blink_on_reg  <= cfg_data;
                REG_BLINK_OFF: blink_off_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Build one lane per channel; channels past four see zero config
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        if (c < CFG_CHANNELS)
        begin : g_cfg
            assign lane_cfg[c].mode     = mode_t'(modes_reg[2*c +: 2]);
            assign lane_cfg[c].dim      = dim_reg[8*c +: 8];
            assign lane_cfg[c].fade_int = fade_int_reg[8*c +: 8];
            assign lane_cfg[c].on_time  = blink_on_reg[8*c +: 8];
            assign lane_cfg[c].off_time = blink_off_reg[8*c +: 8];
            assign lane_want[c]         = in_data.on_requests[c];
        end
        else
        begin : g_nocfg
            assign lane_cfg[c]  = '0;
            assign lane_want[c] = 1'b0;
        end

        lecp_lane u_lane (
            .kind      (in_data.kind),
            .want      (lane_want[c]),
            .tick_next (slow_cnt_next),
            .cfg       (lane_cfg[c]),
            .cur       (lane_reg[c]),
            .nxt       (lane_next[c])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                lane_reg[c] <= '{state: ST_OFF, duty: 8'd0, evt_time: 16'd0};
            end
            else if (in_xfer)
            begin
                lane_reg[c] <= lane_next[c];
            end
        end
    end

    // Gather reported duties; absent channels read as zero
    for (genvar k = 0; k < CFG_CHANNELS; k++)
    begin : g_report
        if (k < CHANNELS)
        begin : g_have
            assign duty_cur[k] = lane_reg[k].duty;
            assign duty_rep[k] = lane_next[k].duty;
        end
        else
        begin : g_none
            assign duty_cur[k] = 8'd0;
            assign duty_rep[k] = 8'd0;
        end
        assign pwm_pins[k] = (pwm_phase_reg < duty_cur[k]);
    end

    assign pin_next = (in_data.kind == KIND_PWM) ? pwm_pins : pin_reg;

    // Advance slow tick counter, pwm phase and pin register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_cnt_reg  <= 16'd0;
            pwm_phase_reg <= 8'd0;
            pin_reg       <= 4'd0;
        end
        else if (in_xfer)
        begin
            if (in_data.kind == KIND_SLOW)
            begin
                slow_cnt_reg <= slow_cnt_next;
            end
            if (in_data.kind == KIND_PWM)
            begin
                pwm_phase_reg <= pwm_phase_reg + 8'd1;
            end
            pin_reg <= pin_next;
        end
    end

    // Form the result item
    always_comb
    begin
        out_next.pin_levels = pin_next;
        out_next.duty_ch0   = duty_rep[0];
        out_next.duty_ch1   = duty_rep[1];
        out_next.duty_ch2   = duty_rep[2];
        out_next.duty_ch3   = duty_rep[3];
    end

    // Hold the result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== tb/tb_led_channel_effect_pwm.sv =====
// Testbench for the LED channel effect PWM block: directed table, slow-tick sweeps, random phases.
`timescale 1ns / 1ps

module tb_led_channel_effect_pwm;
    import lecp_pkg::*;

    localparam int    LANES       = 4;
    localparam int    QUIET_LIMIT = 2000;
    localparam int    PHASES      = 8;
    localparam int    PHASE_ITEMS = 170;
    // Slow ticks in each sweep
    localparam int    SWEEP_TICKS = 100;
    localparam kind_t KIND_SPARE  = 2'd3;
    localparam int    PLAN_ROWS   = 17;
    localparam int    FIRST_MIXED = 10;

    typedef struct packed {
        in_item_t  item;
        logic      fixed;
        out_item_t want;
    } plan_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic      calm         = 1'b0;
    int        fault_count  = 0;
    int        quiet_cycles = 0;
    out_item_t pending_levels [$];

    // Shadow copy of the block's configuration and lamp state
    logic [7:0]  modes_r    = MODES_RST;
    logic [31:0] dim_r      = DIM_RST;
    logic [31:0] fade_r     = FADE_INT_RST;
    logic [31:0] on_r       = BLINK_ON_RST;
    logic [31:0] off_r      = BLINK_OFF_RST;
    logic [15:0] tick_count = '0;
    logic [7:0]  phase      = '0;
    logic [3:0]  pins       = '0;
    logic [15:0] evt_at  [LANES];
    logic [7:0]  duty    [LANES];
    chan_state_t lamp_st [LANES];

    // Directed rows; want holds pins, then duty of channels 0 to 3 from high to low byte
    plan_row_t plan [PLAN_ROWS] = '{
        {KIND_PWM,   4'h0, 1'b1, 4'h0, 32'h0000_0000},
        {KIND_SPARE, 4'hF, 1'b1, 4'h0, 32'h0000_0000},
        {KIND_CMD,   4'hF, 1'b1, 4'h0, 32'h7F7F_7F7F},
        {KIND_PWM,   4'h0, 1'b1, 4'hF, 32'h7F7F_7F7F},
        {KIND_CMD,   4'h0, 1'b1, 4'hF, 32'h0000_0000},
        {KIND_CMD,   4'h5, 1'b1, 4'hF, 32'h7F00_7F00},
        {KIND_PWM,   4'h0, 1'b1, 4'h5, 32'h7F00_7F00},
        {KIND_SLOW,  4'h0, 1'b1, 4'h5, 32'h7F00_7F00},
        {KIND_CMD,   4'hA, 1'b1, 4'h5, 32'h007F_007F},
        {KIND_SPARE, 4'h0, 1'b1, 4'h5, 32'h007F_007F},
        {KIND_CMD,   4'hF, 1'b0, 4'h0, 32'h0000_0000},
        {KIND_PWM,   4'h0, 1'b0, 4'h0, 32'h0000_0000},
        {KIND_SLOW,  4'h0, 1'b0, 4'h0, 32'h0000_0000},
        {KIND_CMD,   4'hE, 1'b0, 4'h0, 32'h0000_0000},
        {KIND_CMD,   4'hF, 1'b0, 4'h0, 32'h0000_0000},
        {KIND_CMD,   4'h7, 1'b0, 4'h0, 32'h0000_0000},
        {KIND_CMD,   4'hF, 1'b0, 4'h0, 32'h0000_0000}
    };

    led_channel_effect_pwm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Apply one item to the shadow lamps and return the levels it leaves behind
    task automatic advance_lamps(input in_item_t item, output out_item_t levels);
        mode_t      m;
        logic       up;
        logic       lit;
        logic [7:0] target;
        logic [7:0] wait_units;
        case (item.kind)
            KIND_CMD:
            begin
                for (int c = 0; c < LANES; c++)
                begin
                    m = mode_t'(modes_r[2*c +: 2]);
                    if (item.on_requests[c])
                    begin
                        if (lamp_st[c] == ST_OFF || lamp_st[c] == ST_DOWN)
                        begin
                            if (m == MODE_ONOFF)
                            begin
                                duty[c]    = dim_r[8*c +: 8];
                                lamp_st[c] = ST_ON;
                            end
                            else if (m == MODE_BLINK)
                                lamp_st[c] = ST_ON;
                            else
                                lamp_st[c] = ST_UP;
                        end
                    end
                    else if (lamp_st[c] == ST_ON || lamp_st[c] == ST_UP)
                    begin
                        if (m == MODE_FADE)
                            lamp_st[c] = ST_DOWN;
                        else
                        begin
                            duty[c]    = 8'h00;
                            lamp_st[c] = ST_OFF;
                        end
                    end
                end
            end
            KIND_SLOW:
            begin
                tick_count = tick_count + 16'd1;
                for (int c = 0; c < LANES; c++)
                begin
                    m = mode_t'(modes_r[2*c +: 2]);
                    // Step a fade by one count at its event time; wrap until the target
                    if (m == MODE_FADE && (lamp_st[c] == ST_UP || lamp_st[c] == ST_DOWN)
                        && tick_count == evt_at[c])
                    begin
                        up        = (lamp_st[c] == ST_UP);
                        target    = up ? dim_r[8*c +: 8] : 8'h00;
                        evt_at[c] = evt_at[c] + {8'h00, fade_r[8*c +: 8]};
                        duty[c]   = up ? duty[c] + 8'd1 : duty[c] - 8'd1;
                        if (duty[c] == target)
                            lamp_st[c] = up ? ST_ON : ST_OFF;
                    end
                    // Toggle a blinking lamp and schedule the next toggle
                    else if (m == MODE_BLINK && lamp_st[c] == ST_ON
                             && tick_count == evt_at[c])
                    begin
                        lit        = (duty[c] != 8'h00);
                        wait_units = lit ? off_r[8*c +: 8] : on_r[8*c +: 8];
                        evt_at[c]  = evt_at[c] + 16'(BLINK_SCALE * wait_units);
                        duty[c]    = lit ? 8'h00 : dim_r[8*c +: 8];
                    end
                end
            end
            KIND_PWM:
            begin
                for (int c = 0; c < LANES; c++)
                    pins[c] = (phase < duty[c]);
                phase = phase + 8'd1;
            end
            default:
            begin
            end
        endcase
        levels = {pins, duty[0], duty[1], duty[2], duty[3]};
    endtask

    // Present one item, hold it until the transfer, then queue its expected levels
    task automatic send_item(input in_item_t item, input logic fixed, input out_item_t want);
        out_item_t forecast;
        if (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_lamps(item, forecast);
        pending_levels.push_back(fixed ? want : forecast);
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_MODES:     modes_r = value[7:0];
            REG_DIM:       dim_r   = value;
            REG_FADE_INT:  fade_r  = value;
            REG_BLINK_ON:  on_r    = value;
            REG_BLINK_OFF: off_r   = value;
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] modes, input logic [31:0] dim,
                               input logic [31:0] fade, input logic [31:0] on_t,
                               input logic [31:0] off_t);
        drain_results();
        write_reg(REG_MODES, {24'h0, modes});
        write_reg(REG_DIM, dim);
        write_reg(REG_FADE_INT, fade);
        write_reg(REG_BLINK_ON, on_t);
        write_reg(REG_BLINK_OFF, off_t);
        cfg_we <= 1'b0;
    endtask

    // Pick four per-channel bytes, weighted toward zero, one and full scale
    function automatic logic [31:0] pick_lanes(input logic timing);
        logic [31:0] word;
        int          r;
        for (int c = 0; c < LANES; c++)
        begin
            r = $urandom_range(9);
            if (r < 2)
                word[8*c +: 8] = 8'h00;
            else if (r < 4)
                word[8*c +: 8] = timing ? 8'h01 : 8'hFF;
            else if (r == 4)
                word[8*c +: 8] = 8'hFF;
            else
                word[8*c +: 8] = timing ? 8'($urandom_range(12, 2)) : 8'($urandom);
        end
        return word;
    endfunction

    // Switch lamps, then run slow ticks with pwm ticks and commands mixed in
    task automatic sweep_ticks(input logic [3:0] on_mask);
        in_item_t item;
        int       slow_sent;
        int       roll;
        slow_sent = 0;
        item.kind        = KIND_CMD;
        item.on_requests = on_mask;
        send_item(item, 1'b0, '0);
        while (slow_sent < SWEEP_TICKS)
        begin
            roll             = $urandom_range(999);
            item.on_requests = 4'($urandom);
            if (roll < 5)
                item.kind = KIND_CMD;
            else if (roll < 200)
                item.kind = KIND_PWM;
            else
            begin
                item.kind = KIND_SLOW;
                slow_sent++;
            end
            send_item(item, 1'b0, '0);
        end
    endtask

    task automatic random_phase();
        in_item_t item;
        int       roll;
        load_config(8'($urandom), pick_lanes(1'b0), pick_lanes(1'b1),
                    pick_lanes(1'b1), pick_lanes(1'b1));
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            roll             = $urandom_range(99);
            item.on_requests = 4'($urandom);
            if (roll < 15)
                item.kind = KIND_CMD;
            else if (roll < 70)
                item.kind = KIND_SLOW;
            else if (roll < 95)
                item.kind = KIND_PWM;
            else
                item.kind = KIND_SPARE;
            send_item(item, 1'b0, '0);
        end
    endtask

    // Compare one field of a result transfer
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Check each result transfer against the oldest expectation, then pick the next ready
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                fault_count++;
            end
            else
            begin
                want = pending_levels.pop_front();
                check_field("pin_levels", {4'h0, want.pin_levels}, {4'h0, out_data.pin_levels});
                check_field("duty_ch0", want.duty_ch0, out_data.duty_ch0);
                check_field("duty_ch1", want.duty_ch1, out_data.duty_ch1);
                check_field("duty_ch2", want.duty_ch2, out_data.duty_ch2);
                check_field("duty_ch3", want.duty_ch3, out_data.duty_ch3);
            end
        end
        out_ready <= calm || ($urandom_range(99) >= 9);
    end

    // End the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        for (int c = 0; c < LANES; c++)
        begin
            evt_at[c]  = '0;
            duty[c]    = '0;
            lamp_st[c] = ST_OFF;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the second part runs one channel in each mode at extreme settings
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (i == FIRST_MIXED)
                load_config(8'h39, 32'hFF80_0300, 32'hFF00_FF01, 32'hFFFF_01FF, 32'hFFFF_02FF);
            send_item(plan[i].item, plan[i].fixed, plan[i].want);
        end
        sweep_ticks(4'hF);

        for (int p = 0; p < PHASES; p++)
        begin
            calm <= (p == 2 || p == 3);
            // Midway, sweep fade with a zero interval and blink with a zero wait
            if (p == PHASES / 2)
            begin
                load_config(8'hA5, 32'hFF40_FF05, 32'h0000_FF00, 32'hFF00_0000, 32'h0301_0000);
                sweep_ticks(4'hF);
            end
            random_phase();
        end

        drain_results();
        repeat (5) @(posedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lecp_pkg.sv
sv/lecp_lane.sv
sv/led_channel_effect_pwm.sv
tb/tb_led_channel_effect_pwm.sv
